// ===== sv/tclb_pkg.sv =====
// Package for the text console line buffer: types, field widths and codes.
package tclb_pkg;

  localparam int DEF_ROWS    = 22;
  localparam int DEF_COLUMNS = 62;

  localparam int CMD_W  = 3;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 6;

  localparam logic [CMD_W-1:0] CMD_PUT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_KEY   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOCK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CHAR_W-1:0] CH_DEL       = 8'd127;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] character;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_column;
  } request_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic              changed;
  } result_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_read;
  } ctl_status_t;

endpackage

// ===== sv/text_console_line_buffer.sv =====
// Top level of the text console line buffer.
// done is registered from the execute state, or for a cell read from the read-finish
// state, which the registered read of the character store needs. A new transfer is
// taken only while busy is low, so one transfer is handled at a time.
// Reset (rst, synchronous): cursor, ring pointer, input start and line-valid flags
// cleared; both stores are left as is. The receiver cannot stall: done lasts one cycle.
module text_console_line_buffer #(
  parameter int ROWS    = tclb_pkg::DEF_ROWS,
  parameter int COLUMNS = tclb_pkg::DEF_COLUMNS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tclb_pkg::request_t request,
  output logic               done,
  output tclb_pkg::result_t  result
);
  import tclb_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  tclb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  tclb_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .request (request),
    .result  (result)
  );

endmodule

// ===== sv/tclb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tclb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/tclb_ctrl.sv =====
// Controller state machine: capture, execute and read-finish sequencing.
module tclb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  tclb_pkg::ctl_status_t status,
  output tclb_pkg::ctl_cmd_t    cmd,
  output logic                  busy,
  output logic                  done
);
  import tclb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       done_next;

  always_comb begin
    state_next  = state;
    done_next   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        if (status.is_read) begin
          state_next = S_READ;
        end else begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end
      S_READ: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
        done_next  = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== sv/tclb_datapath.sv =====
// Datapath: cursor and ring registers, character and line-length stores, result register.
module tclb_datapath #(
  parameter int ROWS    = tclb_pkg::DEF_ROWS,
  parameter int COLUMNS = tclb_pkg::DEF_COLUMNS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tclb_pkg::ctl_cmd_t    cmd,
  output tclb_pkg::ctl_status_t status,
  input  tclb_pkg::request_t    request,
  output tclb_pkg::result_t     result
);
  import tclb_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = ((RW > ROW_W) ? RW : ROW_W) + 1;
  localparam int MW    = (CW > COL_W) ? CW : COL_W;

  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LIMIT = CW'(COLUMNS);
  localparam logic [CW-1:0] KEY_LIMIT = CW'(COLUMNS - 1);

  request_t        req_q;
  logic [RW-1:0]   top, top_next;
  logic [RW-1:0]   cursor_line, cursor_line_next;
  logic [RW-1:0]   cur_phys, cur_phys_next;
  logic [CW-1:0]   cursor_col, cursor_col_next;
  logic [CW-1:0]   input_start, input_start_next;
  logic [ROWS-1:0] line_valid, line_valid_next;
  logic [RW-1:0]   rd_line;
  logic            rd_ok;
  result_t         res_q;

  logic            changed;
  logic            char_we;
  logic            len_we;
  logic [AW-1:0]   char_waddr;
  logic [AW-1:0]   char_raddr;
  logic [CHAR_W-1:0] char_rdata;
  logic [CW-1:0]   len_rdata;

  logic [SW-1:0]   row_sum;
  logic [SW-1:0]   row_wrap;
  logic [RW-1:0]   line_sel;
  logic            row_ok;
  logic            col_ok;
  logic [CW-1:0]   rcol;
  logic [CW-1:0]   rd_len;
  logic            hit;
  logic [CHAR_W-1:0] read_char;

  assign status.is_read = (req_q.command == CMD_READ);
  assign rcol           = CW'(req_q.read_column);

  // Command execution
  always_comb begin
    top_next         = top;
    cursor_line_next = cursor_line;
    cur_phys_next    = cur_phys;
    cursor_col_next  = cursor_col;
    input_start_next = input_start;
    line_valid_next  = line_valid;
    changed          = 1'b0;
    char_we          = 1'b0;
    len_we           = 1'b0;
    if (cmd.execute) begin
      unique case (req_q.command)
        CMD_PUT, CMD_KEY: begin
          if (req_q.character == CH_NEWLINE) begin
            len_we                    = 1'b1;
            line_valid_next[cur_phys] = 1'b1;
            cursor_col_next           = '0;
            cur_phys_next             = (cur_phys == LAST_ROW) ? '0 : cur_phys + RW'(1);
            if (cursor_line == LAST_ROW) begin
              top_next = (top == LAST_ROW) ? '0 : top + RW'(1);
            end else begin
              cursor_line_next = cursor_line + RW'(1);
            end
            changed = (req_q.command == CMD_KEY);
          end else if (req_q.command == CMD_PUT) begin
            if (req_q.character != CH_NUL && cursor_col < COL_LIMIT) begin
              char_we         = 1'b1;
              cursor_col_next = cursor_col + CW'(1);
            end
          end else if (req_q.character == CH_BACKSPACE) begin
            if (cursor_col > input_start) begin
              cursor_col_next = cursor_col - CW'(1);
              changed         = 1'b1;
            end
          end else if (req_q.character >= CH_SPACE && req_q.character < CH_DEL &&
                       cursor_col < KEY_LIMIT) begin
            char_we         = 1'b1;
            cursor_col_next = cursor_col + CW'(1);
            changed         = 1'b1;
          end
        end
        CMD_CLEAR: begin
          line_valid_next  = '0;
          cursor_line_next = '0;
          cursor_col_next  = '0;
          cur_phys_next    = top;
        end
        CMD_LOCK: begin
          input_start_next = cursor_col;
        end
        default: begin
        end
      endcase
    end
  end

  // Read address: screen row to ring line, then cell address
  always_comb begin
    row_sum    = SW'(top) + SW'(req_q.read_row);
    row_wrap   = (row_sum >= SW'(ROWS)) ? row_sum - SW'(ROWS) : row_sum;
    line_sel   = RW'(row_wrap);
    row_ok     = SW'(req_q.read_row) < SW'(ROWS);
    col_ok     = MW'(req_q.read_column) < MW'(COLUMNS);
    char_raddr = AW'(line_sel) * AW'(COLUMNS) + AW'(rcol);
    char_waddr = AW'(cur_phys) * AW'(COLUMNS) + AW'(cursor_col);
  end

  // The cursor line's length is the cursor column itself; an invalid line has length zero
  always_comb begin
    if (rd_line == cur_phys) begin
      rd_len = cursor_col;
    end else if (line_valid[rd_line]) begin
      rd_len = len_rdata;
    end else begin
      rd_len = '0;
    end
    hit       = rd_ok && (rcol < rd_len);
    read_char = hit ? char_rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top         <= '0;
      cursor_line <= '0;
      cur_phys    <= '0;
      cursor_col  <= '0;
      input_start <= '0;
      line_valid  <= '0;
    end else begin
      top         <= top_next;
      cursor_line <= cursor_line_next;
      cur_phys    <= cur_phys_next;
      cursor_col  <= cursor_col_next;
      input_start <= input_start_next;
      line_valid  <= line_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= request;
    end
    if (cmd.execute) begin
      rd_line <= line_sel;
      rd_ok   <= row_ok && col_ok;
    end
    if (cmd.execute && !status.is_read) begin
      res_q.read_char     <= '0;
      res_q.cursor_row    <= ROW_W'(cursor_line_next);
      res_q.cursor_column <= COL_W'(cursor_col_next);
      res_q.changed       <= changed;
    end else if (cmd.finish) begin
      res_q.read_char     <= read_char;
      res_q.cursor_row    <= ROW_W'(cursor_line);
      res_q.cursor_column <= COL_W'(cursor_col);
      res_q.changed       <= 1'b0;
    end
  end

  assign result = res_q;

  tclb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_char_ram (
    .clk     (clk),
    .wr_en   (char_we),
    .wr_addr (char_waddr),
    .wr_data (req_q.character),
    .rd_addr (char_raddr),
    .rd_data (char_rdata)
  );

  tclb_ram #(
    .WIDTH (CW),
    .DEPTH (ROWS)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (len_we),
    .wr_addr (cur_phys),
    .wr_data (cursor_col),
    .rd_addr (line_sel),
    .rd_data (len_rdata)
  );

endmodule

// ===== sv/tclb_checker.sv =====
// Port-level timing checks for the text console line buffer, bound to the top level.
module tclb_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input tclb_pkg::request_t request,
  input logic               done,
  input tclb_pkg::result_t  result
);
  import tclb_pkg::*;

  logic accept;
  assign accept = start && !busy;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy low after a transfer");

  a_done_plain: assert property (@(posedge clk) disable iff (rst)
    (accept && request.command != CMD_READ) |-> ##2 done)
    else $error("result missing two cycles after a command");

  a_done_read: assert property (@(posedge clk) disable iff (rst)
    (accept && request.command == CMD_READ) |-> ##3 done)
    else $error("result missing three cycles after a read");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_no_change_on_read: assert property (@(posedge clk) disable iff (rst)
    (accept && request.command == CMD_READ) |-> ##3 (result.changed == 1'b0))
    else $error("changed set on a cell read");

endmodule

bind text_console_line_buffer tclb_checker u_tclb_checker (.*);
